[design/pfp_pkg.sv]
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants for the pipe FIFO pool.
// ----------------------------------------------------------------------------
`default_nettype none
package pfp_pkg;
	localparam int NUM_PIPES_DEF  = 16;
	localparam int PIPE_BYTES_DEF = 1024;
	localparam int MAX_READ_DEF   = 64;
	localparam int QDEPTH         = 2;

	localparam logic [2:0] ACT_CREATE = 3'd0;
	localparam logic [2:0] ACT_SHARE  = 3'd1;
	localparam logic [2:0] ACT_CLOSE  = 3'd2;
	localparam logic [2:0] ACT_WRITE  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNUSED  = 3'd1;
	localparam logic [2:0] ST_NOFREE  = 3'd2;
	localparam logic [2:0] ST_NORDR   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;
	localparam logic [2:0] ST_ENDED   = 3'd6;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] pipe_index;
		logic       writer_end;
		logic [7:0] data_byte;
		logic [6:0] read_length;
	} cmd_t;
endpackage
`default_nettype wire

[design/pipe_fifo_pool_core.sv]
// ----------------------------------------------------------------------------
// pipe_fifo_pool_core
// Pool of byte FIFOs with reader/writer reference counts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one action per transfer; output
// channel (out_valid/out_stall) carries one result per transfer. A two-entry
// command queue decouples the input from the execution engine.
// Create, share, close and write each give one result from the engine, so one
// byte per cycle is sustained for writes while the receiver does not stall.
// Each action passes the command queue and then the engine; out_valid is registered.
// A read of N bytes gives one result per byte, up to N, MAX_READ and the fill
// (N of zero reads one): a start step, a step to prime the single registered
// read port of the byte store, then one byte per cycle unless out_stall holds.
// Reset clears the pipe table and the pool count; the byte store is not
// cleared. When the receiver stalls, the result holds, the engine stops and
// the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
module pipe_fifo_pool_core #(
	parameter int NUM_PIPES  = pfp_pkg::NUM_PIPES_DEF,
	parameter int PIPE_BYTES = pfp_pkg::PIPE_BYTES_DEF,
	parameter int MAX_READ   = pfp_pkg::MAX_READ_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [3:0]  pipe_index,
	input  wire logic        writer_end,
	input  wire logic [7:0]  data_byte,
	input  wire logic [6:0]  read_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [3:0]       pipe_id,
	output logic [7:0]       data_out,
	output logic [10:0]      pending,
	output logic [4:0]       pipes_in_use,
	output logic             last
);
	pfp_pkg::cmd_t in_cmd, q_cmd;
	logic q_valid, q_take;

	assign in_cmd = '{action: action, pipe_index: pipe_index, writer_end: writer_end,
		data_byte: data_byte, read_length: read_length};

	pfp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
	);

	pfp_back #(.NUM_PIPES(NUM_PIPES), .PIPE_BYTES(PIPE_BYTES), .MAX_READ(MAX_READ)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .pipe_id(pipe_id),
		.data_out(data_out), .pending(pending), .pipes_in_use(pipes_in_use), .last(last)
	);
endmodule
`default_nettype wire

[design/pfp_front.sv]
// ----------------------------------------------------------------------------
// pfp_front
// Input stage and short command queue in front of the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module pfp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire pfp_pkg::cmd_t in_cmd,
	output logic               q_valid,
	input  wire logic          q_take,
	output pfp_pkg::cmd_t      q_cmd
);
	localparam int QD = pfp_pkg::QDEPTH;
	pfp_pkg::cmd_t mem_q [QD];
	logic [$clog2(QD)-1:0] rd_q, wr_q;
	logic [$clog2(QD):0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == ($clog2(QD)+1)'(QD));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_take;
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QD){1'b0}}, push} - {{$clog2(QD){1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

[design/pfp_back.sv]
// ----------------------------------------------------------------------------
// pfp_back
// Executes pipe actions against the pipe table and the byte store.
// ----------------------------------------------------------------------------
`default_nettype none
module pfp_back #(
	parameter int NUM_PIPES  = pfp_pkg::NUM_PIPES_DEF,
	parameter int PIPE_BYTES = pfp_pkg::PIPE_BYTES_DEF,
	parameter int MAX_READ   = pfp_pkg::MAX_READ_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_take,
	input  wire pfp_pkg::cmd_t q_cmd,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         status,
	output logic [3:0]         pipe_id,
	output logic [7:0]         data_out,
	output logic [10:0]        pending,
	output logic [4:0]         pipes_in_use,
	output logic               last
);
	localparam int PW = (PIPE_BYTES > 1) ? $clog2(PIPE_BYTES) : 1;
	localparam int FW = $clog2(PIPE_BYTES + 1);
	localparam int IW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int AW = IW + PW;
	localparam int TW = $clog2(NUM_PIPES + 1);
	localparam int LW = 7;

	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_READ} state_t;
	state_t state_q;

	logic          in_use_q [NUM_PIPES];
	logic [PW-1:0] wp_q     [NUM_PIPES];
	logic [PW-1:0] rp_q     [NUM_PIPES];
	logic [FW-1:0] fill_q   [NUM_PIPES];
	logic [7:0]    rc_q     [NUM_PIPES];
	logic [7:0]    wc_q     [NUM_PIPES];
	logic [TW-1:0] total_q;
	logic [7:0]    store_q  [NUM_PIPES*PIPE_BYTES];

	logic [IW-1:0] rd_pipe_q;
	logic [LW-1:0] left_q;
	logic [7:0]    rdata_q;
	logic [AW-1:0] raddr;
	logic          rd_en;

	logic [IW-1:0] idx;
	logic          idx_ok, valid;
	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [LW-1:0] len, take;
	logic          out_free;

	assign idx = IW'(q_cmd.pipe_index);
	assign idx_ok = (int'(q_cmd.pipe_index) < NUM_PIPES);
	assign valid = idx_ok && in_use_q[idx];
	assign out_free = !out_valid || !out_stall;
	assign q_take = (state_q == S_IDLE) && q_valid && out_free;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int p = NUM_PIPES - 1; p >= 0; p--) begin
			if (!in_use_q[p]) begin
				free_found = 1'b1;
				free_idx = IW'(p);
			end
		end
	end

	always_comb begin
		len = q_cmd.read_length;
		if (len == '0) len = LW'(1);
		if (len > LW'(MAX_READ)) len = LW'(MAX_READ);
		take = ({{(FW > LW ? FW - LW : 0){1'b0}}, len} < FW'(fill_q[idx])) ? len
			: LW'(fill_q[idx]);
	end

	assign raddr = {rd_pipe_q, rp_q[rd_pipe_q]};
	assign rd_en = (state_q == S_FETCH) || ((state_q == S_READ) && out_free && left_q != '0);

	always_ff @(posedge clk) begin
		if (q_take && valid && q_cmd.action == pfp_pkg::ACT_WRITE && rc_q[idx] != '0
			&& fill_q[idx] < FW'(PIPE_BYTES))
			store_q[{idx, wp_q[idx]}] <= q_cmd.data_byte;
		if (rd_en) rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			status <= pfp_pkg::ST_OK;
			pipe_id <= '0;
			data_out <= '0;
			pending <= '0;
			pipes_in_use <= '0;
			last <= 1'b0;
			total_q <= '0;
			rd_pipe_q <= '0;
			left_q <= '0;
			for (int p = 0; p < NUM_PIPES; p++) begin
				in_use_q[p] <= 1'b0;
				wp_q[p] <= '0;
				rp_q[p] <= '0;
				fill_q[p] <= '0;
				rc_q[p] <= '0;
				wc_q[p] <= '0;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_take) begin
						out_valid <= 1'b1;
						pipe_id <= q_cmd.pipe_index;
						data_out <= '0;
						last <= 1'b1;
						pending <= '0;
						pipes_in_use <= 5'(total_q);
						status <= pfp_pkg::ST_OK;
						if (q_cmd.action == pfp_pkg::ACT_CREATE) begin
							if (free_found) begin
								in_use_q[free_idx] <= 1'b1;
								wp_q[free_idx] <= '0;
								rp_q[free_idx] <= '0;
								fill_q[free_idx] <= '0;
								rc_q[free_idx] <= 8'd1;
								wc_q[free_idx] <= 8'd1;
								total_q <= total_q + 1'b1;
								pipes_in_use <= 5'(total_q + 1'b1);
								pipe_id <= 4'(free_idx);
							end else begin
								status <= pfp_pkg::ST_NOFREE;
								pipe_id <= '0;
							end
						end else if (!valid) begin
							status <= pfp_pkg::ST_UNUSED;
						end else begin
							pending <= 11'(fill_q[idx]);
							case (q_cmd.action)
								pfp_pkg::ACT_SHARE: begin
									if (q_cmd.writer_end) begin
										if (wc_q[idx] != 8'hff) wc_q[idx] <= wc_q[idx] + 1'b1;
									end else if (rc_q[idx] != 8'hff) begin
										rc_q[idx] <= rc_q[idx] + 1'b1;
									end
								end
								pfp_pkg::ACT_CLOSE: begin
									logic [7:0] nr, nw;
									nr = rc_q[idx];
									nw = wc_q[idx];
									if (q_cmd.writer_end) begin
										if (nw != '0) nw = nw - 1'b1;
									end else if (nr != '0) begin
										nr = nr - 1'b1;
									end
									rc_q[idx] <= nr;
									wc_q[idx] <= nw;
									if (nr == '0 && nw == '0) begin
										in_use_q[idx] <= 1'b0;
										wp_q[idx] <= '0;
										rp_q[idx] <= '0;
										fill_q[idx] <= '0;
										pending <= '0;
										if (total_q != '0) begin
											total_q <= total_q - 1'b1;
											pipes_in_use <= 5'(total_q - 1'b1);
										end
									end
								end
								pfp_pkg::ACT_WRITE: begin
									if (rc_q[idx] == '0) begin
										status <= pfp_pkg::ST_NORDR;
									end else if (fill_q[idx] >= FW'(PIPE_BYTES)) begin
										status <= pfp_pkg::ST_FULL;
									end else begin
										wp_q[idx] <= (wp_q[idx] == PW'(PIPE_BYTES - 1)) ? '0
											: wp_q[idx] + 1'b1;
										fill_q[idx] <= fill_q[idx] + 1'b1;
										pending <= 11'(fill_q[idx] + 1'b1);
									end
								end
								pfp_pkg::ACT_READ: begin
									if (fill_q[idx] == '0) begin
										status <= (wc_q[idx] == '0) ? pfp_pkg::ST_ENDED
											: pfp_pkg::ST_EMPTY;
									end else begin
										out_valid <= 1'b0;
										fill_q[idx] <= fill_q[idx] - FW'(take);
										pending <= 11'(fill_q[idx] - FW'(take));
										rd_pipe_q <= idx;
										left_q <= take;
										state_q <= S_FETCH;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_FETCH: begin
					rp_q[rd_pipe_q] <= (rp_q[rd_pipe_q] == PW'(PIPE_BYTES - 1)) ? '0
						: rp_q[rd_pipe_q] + 1'b1;
					state_q <= S_READ;
				end
				S_READ: begin
					if (out_free) begin
						if (left_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							out_valid <= 1'b1;
							data_out <= rdata_q;
							last <= (left_q == LW'(1));
							left_q <= left_q - 1'b1;
							if (left_q != LW'(1))
								rp_q[rd_pipe_q] <= (rp_q[rd_pipe_q] == PW'(PIPE_BYTES - 1))
									? '0 : rp_q[rd_pipe_q] + 1'b1;
							else
								state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
